// ----- hdl/rctt_pkg.sv -----
// ----------------------------------------------------------------------------
// rctt_pkg
// Types and codes shared by the reference-counted timer table and its checker.
// ----------------------------------------------------------------------------
package rctt_pkg;

  // command codes
  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_ADD_ONCE = 3'd1;
  localparam logic [2:0] CMD_ADD_HELD = 3'd2;
  localparam logic [2:0] CMD_RELEASE  = 3'd3;
  localparam logic [2:0] CMD_CANCEL   = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_FIRED = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;
  localparam logic [1:0] KIND_REL   = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_WRAP    = 3'd2;
  localparam logic [2:0] ST_NOTLIVE = 3'd3;
  localparam logic [2:0] ST_NOHOLD  = 3'd4;

  // tick step after reset
  localparam logic [9:0] TICK_STEP_RESET = 10'd10;

  // one input item
  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] delay;
    logic [15:0] tag;
    logic [5:0]  slot;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [5:0]  result_slot;
    logic [15:0] fired_tag;
    logic [31:0] now;
    logic        last;
  } result_t;

  // stored timer entry
  typedef struct packed {
    logic [31:0] expiry;
    logic [15:0] tag;
  } entry_t;

endpackage

// ----- hdl/reference_counted_timer_table.sv -----
// ----------------------------------------------------------------------------
// reference_counted_timer_table
// Timer slot table with a wrapping clock, one-shot and held timers, and a
// slot-by-slot expiry scan on every tick.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  cfg       in         cfg_write              cfg_data (tick step)
//  in        in         in_valid / in_stall    in_data  (rctt_pkg::cmd_t)
//  out       out        out_valid / out_stall  out_data (rctt_pkg::result_t)
//
//  One item at a time. A tick scans one slot of the expiry store per cycle
//  through its single read port, and the scan holds on a firing slot for as
//  long as out_stall holds back a pending result.
//  An add searches the slots in order for a free one, and release and
//  cancel answer from S_REL. Unknown commands are dropped in the cycle they arrive.
//  rst is synchronous; the output register keeps its result while stalled.
// ----------------------------------------------------------------------------
module reference_counted_timer_table #(
  parameter int SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [9:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  rctt_pkg::cmd_t     in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rctt_pkg::result_t  out_data
);

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [5:0] SLOTS_W = 6'(SLOTS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STEP = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;
  localparam logic [2:0] S_FIND = 3'd4;
  localparam logic [2:0] S_REL  = 3'd5;

  logic [2:0]        state, state_next;
  rctt_pkg::cmd_t    cmd;
  logic [31:0]       clock_value, clock_value_next;
  logic [9:0]        tick_step;
  logic [IW-1:0]     idx, idx_next;
  logic [SLOTS-1:0]  live, live_next;
  logic [SLOTS-1:0]  held, held_next;
  logic [SLOTS-1:0]  done, done_next;

  logic              accept;
  logic              out_free;
  logic              emit;
  rctt_pkg::result_t res;
  logic [32:0]       sum;
  logic [IW-1:0]     rel_idx;
  logic              rel_ok;
  logic              fire;
  logic              wr_en;
  rctt_pkg::entry_t  wr_data;
  rctt_pkg::entry_t  rd_data;

  // expiry and tag store, read ahead at the next scan index
  rctt_timer_mem #(
    .SLOTS (SLOTS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx),
    .wr_data (wr_data),
    .rd_addr (idx_next),
    .rd_data (rd_data)
  );

  // handshakes
  assign in_stall = rst || (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // shared adder: clock plus step on a tick, clock plus delay on an add
  assign sum = {1'b0, clock_value} +
               ((cmd.command == rctt_pkg::CMD_TICK) ? {23'd0, tick_step}
                                                   : {1'b0, cmd.delay});

  // release and cancel target
  assign rel_idx = cmd.slot[IW-1:0];
  assign rel_ok  = (cmd.slot < SLOTS_W) && live[rel_idx];

  // expiry compare for the slot under scan
  assign fire = live[idx] && !done[idx] && (rd_data.expiry < clock_value);

  assign wr_data.expiry = sum[31:0];
  assign wr_data.tag    = cmd.tag;

  // sequencer
  always_comb begin
    state_next       = state;
    idx_next         = idx;
    clock_value_next = clock_value;
    live_next        = live;
    held_next        = held;
    done_next        = done;
    emit             = 1'b0;
    wr_en            = 1'b0;
    res              = '0;
    res.now          = clock_value;
    res.last         = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_data.command) inside
            rctt_pkg::CMD_TICK: begin
              state_next = S_STEP;
            end
            rctt_pkg::CMD_ADD_ONCE, rctt_pkg::CMD_ADD_HELD: begin
              state_next = S_FIND;
              idx_next   = '0;
            end
            rctt_pkg::CMD_RELEASE, rctt_pkg::CMD_CANCEL: begin
              state_next = S_REL;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_STEP: begin
        clock_value_next = sum[31:0];
        idx_next         = '0;
        state_next       = S_SCAN;
      end

      S_SCAN: begin
        if (fire && !out_free) begin
          idx_next = idx;
        end else begin
          if (fire) begin
            emit            = 1'b1;
            res.kind        = rctt_pkg::KIND_FIRED;
            res.result_slot = 6'(idx);
            res.fired_tag   = rd_data.tag;
            res.last        = 1'b0;
            done_next[idx]  = 1'b1;
          end
          if (live[idx] && (fire || done[idx]) && !held[idx]) begin
            live_next[idx] = 1'b0;
          end
          if (idx == LAST_IDX) begin
            state_next = S_DONE;
          end else begin
            idx_next = idx + IW'(1);
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          emit       = 1'b1;
          res.kind   = rctt_pkg::KIND_TICK;
          state_next = S_IDLE;
        end
      end

      S_FIND: begin
        if (!live[idx]) begin
          if (out_free) begin
            wr_en          = 1'b1;
            live_next[idx] = 1'b1;
            held_next[idx] = (cmd.command == rctt_pkg::CMD_ADD_HELD);
            done_next[idx] = 1'b0;
            emit            = 1'b1;
            res.kind        = rctt_pkg::KIND_ADD;
            res.status      = sum[32] ? rctt_pkg::ST_WRAP : rctt_pkg::ST_OK;
            res.result_slot = 6'(idx);
            state_next      = S_IDLE;
          end
        end else if (idx == LAST_IDX) begin
          if (out_free) begin
            emit       = 1'b1;
            res.kind   = rctt_pkg::KIND_ADD;
            res.status = rctt_pkg::ST_FULL;
            state_next = S_IDLE;
          end
        end else begin
          idx_next = idx + IW'(1);
        end
      end

      S_REL: begin
        if (out_free) begin
          emit            = 1'b1;
          res.kind        = rctt_pkg::KIND_REL;
          res.result_slot = cmd.slot;
          state_next      = S_IDLE;
          if (!rel_ok) begin
            res.status = rctt_pkg::ST_NOTLIVE;
          end else begin
            res.status         = held[rel_idx] ? rctt_pkg::ST_OK : rctt_pkg::ST_NOHOLD;
            held_next[rel_idx] = 1'b0;
            if (cmd.command == rctt_pkg::CMD_CANCEL) begin
              done_next[rel_idx] = 1'b1;
            end
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      idx         <= '0;
      clock_value <= '0;
      tick_step   <= rctt_pkg::TICK_STEP_RESET;
      live        <= '0;
      held        <= '0;
      done        <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      idx         <= idx_next;
      clock_value <= clock_value_next;
      live        <= live_next;
      held        <= held_next;
      done        <= done_next;
      if (cfg_write) begin
        tick_step <= cfg_data;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= in_data;
    end
    if (emit) begin
      out_data <= res;
    end
  end

endmodule

// ----- hdl/rctt_timer_mem.sv -----
// ----------------------------------------------------------------------------
// rctt_timer_mem
// Expiry and tag store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rctt_timer_mem #(
  parameter int SLOTS = 16
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(SLOTS)-1:0]     wr_addr,
  input  rctt_pkg::entry_t             wr_data,
  input  logic [$clog2(SLOTS)-1:0]     rd_addr,
  output rctt_pkg::entry_t             rd_data
);

  rctt_pkg::entry_t mem [SLOTS];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/rctt_checker.sv -----
// ----------------------------------------------------------------------------
// rctt_checker
// Port-level checks on the timer table, bound to the top level.
// ----------------------------------------------------------------------------
module rctt_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input rctt_pkg::cmd_t     in_data,
  input logic               out_valid,
  input logic               out_stall,
  input rctt_pkg::result_t  out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a known command keeps the block busy in the next cycle
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.command == rctt_pkg::CMD_TICK ||
      in_data.command == rctt_pkg::CMD_ADD_ONCE ||
      in_data.command == rctt_pkg::CMD_ADD_HELD ||
      in_data.command == rctt_pkg::CMD_RELEASE ||
      in_data.command == rctt_pkg::CMD_CANCEL) |=> in_stall)
    else $error("block not busy after command transfer");

  // fired results are never final and carry ok status
  a_fired_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == rctt_pkg::KIND_FIRED |->
      !out_data.last && out_data.status == rctt_pkg::ST_OK)
    else $error("malformed fired result");

  // tick-done closes the item with empty slot and tag
  a_tick_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == rctt_pkg::KIND_TICK |->
      out_data.last && out_data.result_slot == 6'd0 && out_data.fired_tag == 16'd0)
    else $error("malformed tick-done result");

  // only fired results carry a tag
  a_tag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind != rctt_pkg::KIND_FIRED |-> out_data.fired_tag == 16'd0)
    else $error("tag on a non-fired result");

endmodule

bind reference_counted_timer_table rctt_checker u_rctt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- dv/reference_counted_timer_table_tb.sv -----
// ----------------------------------------------------------------------------
// reference_counted_timer_table_tb
// Drives command items into the timer table and compares every result transfer
// against an in-bench model of the slots, the wrapping clock and the holds, or
// against the row's own result in a directed table that covers the empty, full,
// wrap and hold-zero corners. Random phases follow, each with its own tick step
// and idling, and one of them holds the output off for a long stretch.
// ----------------------------------------------------------------------------
module reference_counted_timer_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 8;

  // command codes the block ignores
  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  typedef struct {
    rctt_pkg::cmd_t    c;
    int                reps;
    bit                typed;
    rctt_pkg::result_t want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [9:0]        cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  rctt_pkg::cmd_t    in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  rctt_pkg::result_t out_data;

  // timer table model
  logic [9:0]  tmr_step = rctt_pkg::TICK_STEP_RESET;
  logic [31:0] tmr_clock = '0;
  bit          tmr_live [SLOTS];
  bit          tmr_held [SLOTS];
  bit          tmr_done [SLOTS];
  logic [31:0] tmr_expiry [SLOTS];
  logic [15:0] tmr_tag [SLOTS];

  rctt_pkg::result_t item_results[$];
  rctt_pkg::result_t awaited_results[$];
  plan_row_t         plan[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_len = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatch_count = 0;

  reference_counted_timer_table #(
    .SLOTS(SLOTS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // generous limit on the whole run
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic string fmt_result(input rctt_pkg::result_t r);
    return $sformatf("kind %0d status %0d slot %0d tag %h now %h last %0d",
                     r.kind, r.status, r.result_slot, r.fired_tag, r.now, r.last);
  endfunction

  // results one command causes, applied to the model state
  function automatic void predict_timer_results(input rctt_pkg::cmd_t c);
    rctt_pkg::result_t r;
    int                i;
    int                free_idx;
    logic [31:0]       exp_v;
    item_results.delete();
    r = '0;
    r.last = 1'b1;
    case (c.command) inside
      rctt_pkg::CMD_TICK: begin
        tmr_clock = tmr_clock + {22'd0, tmr_step};
        for (i = 0; i < SLOTS; i++) begin
          if (tmr_live[i]) begin
            if (!tmr_done[i] && tmr_expiry[i] < tmr_clock) begin
              tmr_done[i] = 1'b1;
              item_results.push_back('{kind: rctt_pkg::KIND_FIRED, status: rctt_pkg::ST_OK,
                                       result_slot: 6'(i), fired_tag: tmr_tag[i],
                                       now: tmr_clock, last: 1'b0});
            end
            if (tmr_done[i] && !tmr_held[i]) tmr_live[i] = 1'b0;
          end
        end
        r.kind = rctt_pkg::KIND_TICK;
        r.status = rctt_pkg::ST_OK;
      end
      rctt_pkg::CMD_ADD_ONCE, rctt_pkg::CMD_ADD_HELD: begin
        free_idx = -1;
        for (i = SLOTS - 1; i >= 0; i--) begin
          if (!tmr_live[i]) free_idx = i;
        end
        r.kind = rctt_pkg::KIND_ADD;
        if (free_idx < 0) begin
          r.status = rctt_pkg::ST_FULL;
        end else begin
          exp_v = tmr_clock + c.delay;
          r.status = (exp_v < tmr_clock) ? rctt_pkg::ST_WRAP : rctt_pkg::ST_OK;
          r.result_slot = 6'(free_idx);
          tmr_live[free_idx] = 1'b1;
          tmr_held[free_idx] = (c.command == rctt_pkg::CMD_ADD_HELD);
          tmr_done[free_idx] = 1'b0;
          tmr_expiry[free_idx] = exp_v;
          tmr_tag[free_idx] = c.tag;
        end
      end
      rctt_pkg::CMD_RELEASE, rctt_pkg::CMD_CANCEL: begin
        r.kind = rctt_pkg::KIND_REL;
        r.result_slot = c.slot;
        if (c.slot >= SLOTS) begin
          r.status = rctt_pkg::ST_NOTLIVE;
        end else if (!tmr_live[c.slot]) begin
          r.status = rctt_pkg::ST_NOTLIVE;
        end else begin
          r.status = tmr_held[c.slot] ? rctt_pkg::ST_OK : rctt_pkg::ST_NOHOLD;
          tmr_held[c.slot] = 1'b0;
          if (c.command == rctt_pkg::CMD_CANCEL) tmr_done[c.slot] = 1'b1;
        end
      end
      default: begin
        return;
      end
    endcase
    r.now = tmr_clock;
    item_results.push_back(r);
  endfunction

  // mostly well-formed traffic, some noise on slots, delays and commands
  function automatic rctt_pkg::cmd_t pick_timer_cmd();
    rctt_pkg::cmd_t c;
    int             sel;
    int             i;
    int             live_idx[$];
    c.tag = 16'($urandom);
    c.delay = $urandom;
    c.slot = 6'($urandom_range(63));
    sel = $urandom_range(99);
    if (sel < 30) begin
      // short delay, fires within a few ticks
      c.command = $urandom_range(1) ? rctt_pkg::CMD_ADD_HELD : rctt_pkg::CMD_ADD_ONCE;
      c.delay = $urandom_range(3 * tmr_step + 2);
    end else if (sel < 36) begin
      // any delay, or one that wraps past the top of the clock
      c.command = $urandom_range(1) ? rctt_pkg::CMD_ADD_HELD : rctt_pkg::CMD_ADD_ONCE;
      if ($urandom_range(1)) c.delay = 32'hFFFF_FFFF - $urandom_range(64);
    end else if (sel < 56) begin
      c.command = rctt_pkg::CMD_TICK;
    end else if (sel < 82) begin
      c.command = $urandom_range(1) ? rctt_pkg::CMD_CANCEL : rctt_pkg::CMD_RELEASE;
      for (i = 0; i < SLOTS; i++) begin
        if (tmr_live[i]) live_idx.push_back(i);
      end
      if (live_idx.size() != 0) c.slot = 6'(live_idx[$urandom_range(live_idx.size() - 1)]);
    end else if (sel < 94) begin
      c.command = $urandom_range(1) ? rctt_pkg::CMD_CANCEL : rctt_pkg::CMD_RELEASE;
    end else begin
      c.command = 3'($urandom_range(CMD_RSVD5, CMD_RSVD7));
    end
    return c;
  endfunction

  // offer one command and record what it should cause once transferred
  task automatic drive_cmd(input rctt_pkg::cmd_t c, input bit typed,
                           input rctt_pkg::result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (in_stall);
    predict_timer_results(c);
    if (typed) begin
      awaited_results.push_back(want);
    end else begin
      foreach (item_results[k]) awaited_results.push_back(item_results[k]);
    end
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tick_step(input logic [9:0] step);
    cfg_write <= 1'b1;
    cfg_data <= step;
    @(posedge clk);
    tmr_step = step;
    cfg_write <= 1'b0;
  endtask

  task automatic plan_row(input logic [2:0] cmd, input logic [31:0] delay,
                          input logic [15:0] tag, input logic [5:0] slot, input int reps,
                          input bit typed, input logic [1:0] kind, input logic [2:0] status,
                          input logic [5:0] rslot, input logic [31:0] now);
    plan_row_t row;
    row.c = '{command: cmd, delay: delay, tag: tag, slot: slot};
    row.reps = reps;
    row.typed = typed;
    row.want = '{kind: kind, status: status, result_slot: rslot, fired_tag: 16'h0000,
                 now: now, last: 1'b1};
    plan.push_back(row);
  endtask

  task automatic run_phase(input logic [9:0] step, input int send_pct, input int rx_pct,
                           input int n_items, input int hold_cycles, input bit pause_mid);
    rctt_pkg::cmd_t    c;
    rctt_pkg::result_t none;
    int                sent;
    bit                paused;
    wait_drained();
    write_tick_step(step);
    send_idle_pct = send_pct;
    stall_pct = rx_pct;
    if (hold_cycles != 0) begin
      hold_len = hold_cycles;
      hold_asks++;
    end
    none = '0;
    sent = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      c = pick_timer_cmd();
      drive_cmd(c, 1'b0, none);
      if (c.command <= rctt_pkg::CMD_CANCEL) sent++;
      if (pause_mid && !paused && sent >= n_items / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end
  endtask

  // receiver side: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = hold_len;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    rctt_pkg::result_t want;
    string             bad;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch({"unexpected result: ", fmt_result(out_data)});
      end else begin
        want = awaited_results.pop_front();
        bad = "";
        if (out_data.kind !== want.kind) bad = {bad, " kind"};
        if (out_data.status !== want.status) bad = {bad, " status"};
        if (out_data.result_slot !== want.result_slot) bad = {bad, " result_slot"};
        if (out_data.fired_tag !== want.fired_tag) bad = {bad, " fired_tag"};
        if (out_data.now !== want.now) bad = {bad, " now"};
        if (out_data.last !== want.last) bad = {bad, " last"};
        if (bad != "") begin
          report_mismatch($sformatf("wrong%s: got %s, want %s", bad,
                                    fmt_result(out_data), fmt_result(want)));
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed corners, starting from the reset step of 10
    plan_row(rctt_pkg::CMD_RELEASE,  32'd0,         16'h0000, 6'd0,  1,  1'b1,
             rctt_pkg::KIND_REL,  rctt_pkg::ST_NOTLIVE, 6'd0,  32'd0);
    plan_row(rctt_pkg::CMD_CANCEL,   32'd0,         16'h0000, 6'd63, 1,  1'b1,
             rctt_pkg::KIND_REL,  rctt_pkg::ST_NOTLIVE, 6'd63, 32'd0);
    plan_row(rctt_pkg::CMD_TICK,     32'd0,         16'h0000, 6'd0,  1,  1'b1,
             rctt_pkg::KIND_TICK, rctt_pkg::ST_OK,      6'd0,  32'd10);
    plan_row(rctt_pkg::CMD_ADD_ONCE, 32'd0,         16'hFFFF, 6'd0,  1,  1'b1,
             rctt_pkg::KIND_ADD,  rctt_pkg::ST_OK,      6'd0,  32'd10);
    plan_row(rctt_pkg::CMD_ADD_HELD, 32'hFFFF_FFFF, 16'h0000, 6'd0,  1,  1'b1,
             rctt_pkg::KIND_ADD,  rctt_pkg::ST_WRAP,    6'd1,  32'd10);
    plan_row(rctt_pkg::CMD_ADD_HELD, 32'd5,         16'h1234, 6'd0,  1,  1'b1,
             rctt_pkg::KIND_ADD,  rctt_pkg::ST_OK,      6'd2,  32'd10);
    // fill the rest of the table, all due on the next tick
    plan_row(rctt_pkg::CMD_ADD_HELD, 32'd9,         16'h8001, 6'd0,  13, 1'b0,
             rctt_pkg::KIND_ADD,  rctt_pkg::ST_OK,      6'd0,  32'd0);
    plan_row(rctt_pkg::CMD_ADD_ONCE, 32'd1,         16'h4321, 6'd0,  1,  1'b1,
             rctt_pkg::KIND_ADD,  rctt_pkg::ST_FULL,    6'd0,  32'd10);
    plan_row(CMD_RSVD5,              32'hFFFF_FFFF, 16'hFFFF, 6'd63, 1,  1'b0,
             rctt_pkg::KIND_ADD,  rctt_pkg::ST_OK,      6'd0,  32'd0);
    plan_row(rctt_pkg::CMD_RELEASE,  32'd0,         16'h0000, 6'd2,  1,  1'b1,
             rctt_pkg::KIND_REL,  rctt_pkg::ST_OK,      6'd2,  32'd10);
    plan_row(rctt_pkg::CMD_RELEASE,  32'd0,         16'h0000, 6'd2,  1,  1'b1,
             rctt_pkg::KIND_REL,  rctt_pkg::ST_NOHOLD,  6'd2,  32'd10);
    plan_row(rctt_pkg::CMD_CANCEL,   32'd0,         16'h0000, 6'd3,  1,  1'b1,
             rctt_pkg::KIND_REL,  rctt_pkg::ST_OK,      6'd3,  32'd10);
    plan_row(rctt_pkg::CMD_CANCEL,   32'd0,         16'h0000, 6'd3,  1,  1'b1,
             rctt_pkg::KIND_REL,  rctt_pkg::ST_NOHOLD,  6'd3,  32'd10);
    // one-shot cancel with no hold still marks it done
    plan_row(rctt_pkg::CMD_CANCEL,   32'd0,         16'h0000, 6'd0,  1,  1'b1,
             rctt_pkg::KIND_REL,  rctt_pkg::ST_NOHOLD,  6'd0,  32'd10);
    plan_row(rctt_pkg::CMD_RELEASE,  32'd0,         16'h0000, 6'd16, 1,  1'b1,
             rctt_pkg::KIND_REL,  rctt_pkg::ST_NOTLIVE, 6'd16, 32'd10);
    plan_row(rctt_pkg::CMD_TICK,     32'd0,         16'h0000, 6'd0,  1,  1'b0,
             rctt_pkg::KIND_ADD,  rctt_pkg::ST_OK,      6'd0,  32'd0);
    plan_row(CMD_RSVD7,              32'd0,         16'h0000, 6'd0,  1,  1'b0,
             rctt_pkg::KIND_ADD,  rctt_pkg::ST_OK,      6'd0,  32'd0);
    plan_row(rctt_pkg::CMD_TICK,     32'd0,         16'h0000, 6'd0,  1,  1'b0,
             rctt_pkg::KIND_ADD,  rctt_pkg::ST_OK,      6'd0,  32'd0);
    plan_row(rctt_pkg::CMD_CANCEL,   32'd0,         16'h0000, 6'd4,  1,  1'b0,
             rctt_pkg::KIND_ADD,  rctt_pkg::ST_OK,      6'd0,  32'd0);
    plan_row(CMD_RSVD6,              32'h5555_AAAA, 16'hA5A5, 6'd21, 1,  1'b0,
             rctt_pkg::KIND_ADD,  rctt_pkg::ST_OK,      6'd0,  32'd0);
    plan_row(rctt_pkg::CMD_ADD_ONCE, 32'd100,       16'h5A5A, 6'd0,  1,  1'b0,
             rctt_pkg::KIND_ADD,  rctt_pkg::ST_OK,      6'd0,  32'd0);
    plan_row(rctt_pkg::CMD_ADD_HELD, 32'h7FFF_FFFF, 16'h0001, 6'd0,  1,  1'b0,
             rctt_pkg::KIND_ADD,  rctt_pkg::ST_OK,      6'd0,  32'd0);
    plan_row(rctt_pkg::CMD_TICK,     32'd0,         16'h0000, 6'd0,  1,  1'b0,
             rctt_pkg::KIND_ADD,  rctt_pkg::ST_OK,      6'd0,  32'd0);

    foreach (plan[k]) begin
      repeat (plan[k].reps) drive_cmd(plan[k].c, plan[k].typed, plan[k].want);
    end

    // random phases: step, sender idle %, receiver stall %, items, hold-off, mid pause
    run_phase(10'd1,    0,  0,  50, 0,   1'b0);
    run_phase(10'd0,    52, 0,  50, 0,   1'b0);
    run_phase(10'd1023, 0,  52, 50, 0,   1'b0);
    run_phase(10'd1000, 21, 21, 50, 0,   1'b0);
    run_phase(10'($urandom_range(1, 1000)), 21, 21, 65, 400, 1'b0);
    run_phase(10'($urandom_range(2, 40)),   0,  0,  65, 0,   1'b1);

    wait_drained();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- reference_counted_timer_table.f -----
hdl/rctt_pkg.sv
hdl/rctt_timer_mem.sv
hdl/reference_counted_timer_table.sv
hdl/rctt_checker.sv
dv/reference_counted_timer_table_tb.sv
